/* hw/rtl/ssp_pkg.sv */
// ssp_pkg: shared types for the smallest string period block
// holds the controller state enum and the command and status structs
// no dependencies
package ssp_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_LOAD,
    ST_DIV,
    ST_EMIT
  } ssp_state_e;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic walk_step;
    logic finish;
    logic div_load;
    logic div_step;
    logic load_out;
  } ssp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic match;
    logic j_zero;
    logic div_done;
    logic out_free;
    logic last;
  } ssp_status_t;

endpackage

/* hw/rtl/smallest_string_period_unit.sv */
// smallest_string_period_unit: top level of the smallest string period block
// depends on ssp_pkg, ssp_ctrl and ssp_datapath
//
// usage
//   input channel: symbol_i and last_i with in_valid_i / in_stall_o; a transfer
//   happens on a rising edge with valid high and stall low. last_i marks the
//   final byte of a string.
//   output channel: period_o, length_o, overflow_o with out_valid_o /
//   out_stall_i; one transfer per string, after its final byte.
//   each byte is stored and its prefix-function entry built by walking earlier
//   failure links. a byte at position zero, or one dropped because MAX_LEN
//   bytes are already stored, needs no walk; any other byte probes the
//   previous link and then one entry per extra failure link followed
//   (amortized under one per byte), one probe at a time, set by the single
//   read port of the prefix table. a final byte then runs the restoring remainder
//   unit (one bit per cycle), after which the result enters the output register.
//   reset clears the length, the overflow flag and the output valid; the stores
//   need no clearing. a stalled result holds its register; the next string's
//   bytes are taken meanwhile, and only the next result waits for it.
module smallest_string_period_unit #(
  parameter int MAX_LEN = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] symbol_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] period_o,
  output logic [7:0] length_o,
  output logic       overflow_o
);
  import ssp_pkg::*;

  ssp_cmd_t    cmd;
  ssp_status_t status;

  ssp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .last_i     (last_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ssp_datapath #(
    .MAX_LEN (MAX_LEN)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .symbol_i    (symbol_i),
    .last_i      (last_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .period_o    (period_o),
    .length_o    (length_o),
    .overflow_o  (overflow_o)
  );

endmodule

/* hw/rtl/ssp_ctrl.sv */
// ssp_ctrl: sequencing state machine for the smallest string period block
// depends on ssp_pkg for the state enum and the command and status structs
module ssp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                last_i,
  output logic                in_stall_o,
  input  ssp_pkg::ssp_status_t status_i,
  output ssp_pkg::ssp_cmd_t    cmd_o
);
  import ssp_pkg::*;

  ssp_state_e state_q, state_d;
  logic       walk_end;

  assign walk_end = status_i.match | status_i.j_zero;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (status_i.full || status_i.empty) begin
            state_d = last_i ? ST_LOAD : ST_IDLE;
          end else begin
            state_d = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (walk_end) begin
          state_d = status_i.last ? ST_LOAD : ST_IDLE;
        end
      end
      ST_LOAD: state_d = ST_DIV;
      ST_DIV: begin
        if (status_i.div_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      ST_WALK: begin
        cmd_o.walk_step = ~walk_end;
        cmd_o.finish    = walk_end;
      end
      ST_LOAD: cmd_o.div_load = 1'b1;
      ST_DIV:  cmd_o.div_step = 1'b1;
      ST_EMIT: cmd_o.load_out = status_i.out_free;
      default: in_stall_o = 1'b1;
    endcase
  end

endmodule

/* hw/rtl/ssp_datapath.sv */
// ssp_datapath: text store, prefix table, failure walk, remainder unit, output register
// depends on ssp_pkg for the command and status structs
module ssp_datapath #(
  parameter int MAX_LEN = 128
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [7:0]           symbol_i,
  input  logic                 last_i,
  input  ssp_pkg::ssp_cmd_t    cmd_i,
  output ssp_pkg::ssp_status_t status_o,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output logic [7:0]           period_o,
  output logic [7:0]           length_o,
  output logic                 overflow_o
);
  import ssp_pkg::*;

  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int AW = $clog2(MAX_LEN);
  localparam int BW = $clog2(CW);
  localparam logic [CW-1:0] FULL_CNT = CW'(MAX_LEN);
  localparam logic [BW-1:0] TOP_BIT  = BW'(CW - 1);

  logic [7:0]    text_mem [MAX_LEN];
  logic [AW-1:0] pt_mem   [MAX_LEN + 1];

  logic [CW-1:0] count_q;
  logic          ovf_q;
  logic [AW-1:0] prev_link_q;
  logic [7:0]    sym_q;
  logic          last_q;
  logic [AW-1:0] j_q;
  logic [7:0]    text_rd_q;
  logic [AW-1:0] pt_rd_q;

  logic [CW-1:0] n_q, p_q, r_q;
  logic [BW-1:0] bit_q;
  logic          ovf_snap_q;

  logic          out_valid_q;
  logic [7:0]    period_q, length_q;
  logic          overflow_q;

  logic          full, empty, match, store_new;
  logic [AW-1:0] pos, link, rd_addr;
  logic          rd_en, pt_we;
  logic [AW-1:0] pt_wdata;
  logic [CW-1:0] pt_waddr;
  logic [CW:0]   r_shift;
  logic [CW-1:0] r_next, period_sel;
  logic [CW+7:0] period_ext, length_ext;

  assign full      = (count_q == FULL_CNT);
  assign empty     = (count_q == '0);
  assign pos       = count_q[AW-1:0];
  assign match     = (text_rd_q == sym_q);
  assign link      = match ? AW'(j_q + 1'b1) : '0;
  assign store_new = cmd_i.accept & ~full;

  // first probe uses the link of the previous prefix, later ones follow the table
  assign rd_en   = cmd_i.accept | cmd_i.walk_step;
  assign rd_addr = cmd_i.walk_step ? pt_rd_q : prev_link_q;

  // a byte at position zero finishes at once with a zero link
  assign pt_we    = cmd_i.finish | (store_new & empty);
  assign pt_wdata = cmd_i.finish ? link : '0;
  assign pt_waddr = CW'(count_q + 1'b1);

  always_ff @(posedge clk_i) begin
    if (store_new) begin
      text_mem[pos] <= symbol_i;
    end
    if (pt_we) begin
      pt_mem[pt_waddr] <= pt_wdata;
    end
    if (rd_en) begin
      text_rd_q <= text_mem[rd_addr];
      pt_rd_q   <= pt_mem[CW'(rd_addr)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        last_q <= last_i;
        if (full) begin
          ovf_q <= 1'b1;
        end
      end
      if (pt_we) begin
        count_q <= CW'(count_q + 1'b1);
      end
      if (cmd_i.div_load) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sym_q <= symbol_i;
    end
    if (rd_en) begin
      j_q <= rd_addr;
    end
    if (pt_we) begin
      prev_link_q <= pt_wdata;
    end
  end

  // restoring remainder n mod p, one bit of n per cycle
  assign r_shift = {r_q, n_q[bit_q]};
  assign r_next  = (r_shift >= {1'b0, p_q}) ? CW'(r_shift - {1'b0, p_q}) : r_shift[CW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      n_q        <= count_q;
      p_q        <= CW'(count_q - CW'(prev_link_q));
      r_q        <= '0;
      bit_q      <= TOP_BIT;
      ovf_snap_q <= ovf_q;
    end else if (cmd_i.div_step) begin
      r_q   <= r_next;
      bit_q <= BW'(bit_q - 1'b1);
    end
  end

  assign period_sel = (r_q == '0) ? p_q : n_q;
  assign period_ext = {8'b0, period_sel};
  assign length_ext = {8'b0, n_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      period_q   <= period_ext[7:0];
      length_q   <= length_ext[7:0];
      overflow_q <= ovf_snap_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign period_o    = period_q;
  assign length_o    = length_q;
  assign overflow_o  = overflow_q;

  always_comb begin
    status_o          = '0;
    status_o.full     = full;
    status_o.empty    = empty;
    status_o.match    = match;
    status_o.j_zero   = (j_q == '0);
    status_o.div_done = (bit_q == '0);
    status_o.out_free = ~out_valid_q | ~out_stall_i;
    status_o.last     = last_q;
  end

endmodule

/* hw/rtl/ssp_checker.sv */
// ssp_checker: port-level assertions for smallest_string_period_unit
// bound to the top level below; no package dependency
module ssp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       last_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] period_o,
  input logic [7:0] length_o,
  input logic       overflow_o
);

  logic in_xfer;
  assign in_xfer = in_valid_i & ~in_stall_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(period_o) && $stable(length_o) && $stable(overflow_o))
    else $error("stalled result changed");

  // only a final byte can produce a result
  a_no_result_midstring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && !last_i |=> !$rose(out_valid_o))
    else $error("result raised by a non-final byte");

  // a final byte always starts the period computation, so input is held off
  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && last_i |=> in_stall_o)
    else $error("input taken during period computation");

endmodule

bind smallest_string_period_unit ssp_checker u_ssp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .last_i      (last_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .period_o    (period_o),
  .length_o    (length_o),
  .overflow_o  (overflow_o)
);
